// ----- src/gqg_pkg.sv -----
// Package of the Gaussian quaternion generator: constants, datapath command
// and status types, controller state type and the series divisor tables.
// No dependencies.
package gqg_pkg;

    localparam int OUT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF = 12;

    localparam int SEED_W = 31;
    localparam logic [SEED_W-1:0] MODULUS = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam logic [32:0] TWO_LN2 = 33'd5954088944;
    localparam logic [32:0] HALF_PI = 33'd6746518852;

    localparam int MUL_A_W = 40;
    localparam int MUL_AH = 20;
    localparam int MUL_B_W = 34;
    localparam int PP_W = MUL_AH + MUL_B_W;
    localparam int PROD_W = 74;

    localparam int DIV_W = 34;
    localparam int DIVISOR_W = 9;
    localparam int RCP_W = 40;
    localparam int SUM_W = 36;

    localparam int LOG_ITERS = 32;
    localparam int SQRT_ITERS = 32;
    localparam int SERIES_TERMS = 8;
    localparam int CNT_W = 6;
    localparam int TERM_W = 3;

    localparam logic [DIVISOR_W-1:0] SIN_DIV [SERIES_TERMS] =
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [DIVISOR_W-1:0] COS_DIV [SERIES_TERMS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

    localparam logic [RCP_W-1:0] SIN_RCP [SERIES_TERMS] = '{
        RCP_W'((64'd1 << RCP_W) / 64'd6),   RCP_W'((64'd1 << RCP_W) / 64'd20),
        RCP_W'((64'd1 << RCP_W) / 64'd42),  RCP_W'((64'd1 << RCP_W) / 64'd72),
        RCP_W'((64'd1 << RCP_W) / 64'd110), RCP_W'((64'd1 << RCP_W) / 64'd156),
        RCP_W'((64'd1 << RCP_W) / 64'd210), RCP_W'((64'd1 << RCP_W) / 64'd272)};
    localparam logic [RCP_W-1:0] COS_RCP [SERIES_TERMS] = '{
        RCP_W'((64'd1 << RCP_W) / 64'd2),   RCP_W'((64'd1 << RCP_W) / 64'd12),
        RCP_W'((64'd1 << RCP_W) / 64'd30),  RCP_W'((64'd1 << RCP_W) / 64'd56),
        RCP_W'((64'd1 << RCP_W) / 64'd90),  RCP_W'((64'd1 << RCP_W) / 64'd132),
        RCP_W'((64'd1 << RCP_W) / 64'd182), RCP_W'((64'd1 << RCP_W) / 64'd240)};

    typedef enum logic [3:0] {
        MS_LCG, MS_SQR, MS_LN, MS_TH, MS_X2, MS_TS, MS_TC, MS_OC, MS_OS, MS_RCP
    } mul_sel_t;

    typedef enum logic [1:0] {
        MP_NONE, MP_LO, MP_HI
    } mul_ph_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LCG_RED, OP_LOG_INIT, OP_LOG_NORM, OP_LOG_SQ, OP_LOG_L,
        OP_SQRT_INIT, OP_SQRT_STEP, OP_TH_SET, OP_X2_SET, OP_DIV_INIT,
        OP_DIV_STEP, OP_TS_SET, OP_TC_SET, OP_TRIG, OP_OUT_SET
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        mul_sel_t           mul_sel;
        mul_ph_t            mul_ph;
        logic               cos_sel;
        logic [TERM_W-1:0]  term;
        logic [1:0]         slot;
        logic               out_load;
    } gqg_cmd_t;

    typedef struct packed {
        logic norm_done;
    } gqg_status_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RL_LO, S_RL_HI, S_RL_RED,
        S_LOG_INIT, S_LOG_NORM,
        S_SQ_LO, S_SQ_HI, S_SQ_UPD,
        S_LOG_L, S_LN_LO, S_LN_HI,
        S_SQRT_INIT, S_SQRT_STEP,
        S_AL_LO, S_AL_HI, S_AL_RED,
        S_TH_LO, S_TH_HI, S_TH_SET,
        S_X2_LO, S_X2_HI, S_X2_SET,
        S_TS_LO, S_TS_HI, S_TS_DIVI, S_TS_DIV, S_TS_SET,
        S_TC_LO, S_TC_HI, S_TC_DIVI, S_TC_DIV, S_TC_SET,
        S_TRIG,
        S_OC_LO, S_OC_HI, S_OC_SET,
        S_OS_LO, S_OS_HI, S_OS_SET,
        S_DONE
    } fsm_state_t;

    function automatic logic [DIVISOR_W-1:0] series_divisor(
        input logic [TERM_W-1:0] term,
        input logic              cos_sel
    );
        return cos_sel ? COS_DIV[term] : SIN_DIV[term];
    endfunction

    function automatic logic [RCP_W-1:0] series_recip(
        input logic [TERM_W-1:0] term,
        input logic              cos_sel
    );
        return cos_sel ? COS_RCP[term] : SIN_RCP[term];
    endfunction

endpackage

// ----- src/gqg_if.sv -----
// Channel interfaces of the Gaussian quaternion generator: request,
// seed write and quaternion result. Depends on gqg_pkg.
interface gqg_req_if;
    logic valid;
    logic ready;
    logic request;
    modport source (output valid, output request, input ready);
    modport sink (input valid, input request, output ready);
endinterface

interface gqg_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [gqg_pkg::SEED_W-1:0] seed_value;
    modport source (output valid, output seed_value, input ready);
    modport sink (input valid, input seed_value, output ready);
endinterface

interface gqg_quat_if #(
    parameter int OUT_WIDTH = gqg_pkg::OUT_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] comp_w;
    logic signed [OUT_WIDTH-1:0] comp_x;
    logic signed [OUT_WIDTH-1:0] comp_y;
    logic signed [OUT_WIDTH-1:0] comp_z;
    modport source (output valid, output comp_w, output comp_x, output comp_y,
                    output comp_z, input ready);
    modport sink (input valid, input comp_w, input comp_x, input comp_y,
                  input comp_z, output ready);
endinterface

// ----- src/gqg_datapath.sv -----
// Datapath of the Gaussian quaternion generator: generator state, shared
// split multiplier, log, square root, series divider and output stage.
// Depends on gqg_pkg; driven by gqg_ctrl commands.
module gqg_datapath #(
    parameter int OUT_WIDTH = gqg_pkg::OUT_WIDTH_DEF,
    parameter int FRAC_BITS = gqg_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gqg_pkg::gqg_cmd_t              cmd,
    output gqg_pkg::gqg_status_t           status,
    input  logic                           seed_we,
    input  logic [gqg_pkg::SEED_W-1:0]     seed_data,
    output logic signed [OUT_WIDTH-1:0]    comp_w,
    output logic signed [OUT_WIDTH-1:0]    comp_x,
    output logic signed [OUT_WIDTH-1:0]    comp_y,
    output logic signed [OUT_WIDTH-1:0]    comp_z
);
    import gqg_pkg::*;

    localparam int SH = 61 - FRAC_BITS;

    logic [SEED_W-1:0]          state_reg, state_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [30:0]                m_reg, m_next;
    logic [4:0]                 e_reg, e_next;
    logic [31:0]                frac_reg, frac_next;
    logic [36:0]                l_reg, l_next;
    logic [63:0]                sq_v_reg, sq_v_next;
    logic [63:0]                sq_res_reg, sq_res_next;
    logic [63:0]                sq_bit_reg, sq_bit_next;
    logic [32:0]                th_reg, th_next;
    logic [DIV_W-1:0]           x2_reg, x2_next;
    logic [DIV_W-1:0]           ts_reg, ts_next;
    logic [DIV_W-1:0]           tc_reg, tc_next;
    logic signed [SUM_W-1:0]    ss_reg, ss_next;
    logic signed [SUM_W-1:0]    cs_reg, cs_next;
    logic [DIV_W-1:0]           div_q_reg, div_q_next;
    logic [DIVISOR_W-1:0]       div_d_reg, div_d_next;
    logic [RCP_W-1:0]           div_rcp_reg, div_rcp_next;
    logic                       co_neg_reg, co_neg_next;
    logic                       si_neg_reg, si_neg_next;
    logic [32:0]                co_mag_reg, co_mag_next;
    logic [32:0]                si_mag_reg, si_mag_next;
    logic [OUT_WIDTH-1:0]       res_reg [4];
    logic [OUT_WIDTH-1:0]       res_val;
    logic [OUT_WIDTH-1:0]       out_w_reg, out_x_reg, out_y_reg, out_z_reg;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PP_W-1:0]            pp;
    logic [31:0]                lcg_sum;
    logic [SEED_W-1:0]          lcg_red;
    logic [31:0]                m2;
    logic [63:0]                sq_t;
    logic [DIV_W-1:0]           q_est;
    logic [DIV_W+DIVISOR_W-1:0] q_mul;
    logic [DIV_W-1:0]           q_rem;
    logic signed [SUM_W-1:0]    div_ext;
    logic [32:0]                c_cl, s_cl;
    logic [PROD_W-1:0]          rnd, vq, lim;
    logic                       o_neg;

    function automatic logic [32:0] clamp_unit(input logic signed [SUM_W-1:0] v);
        logic [32:0] r;
        if (v < 0)
            r = '0;
        else if (v > SUM_W'(64'sh1_0000_0000))
            r = 33'h1_0000_0000;
        else
            r = v[32:0];
        return r;
    endfunction

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_LCG:
            begin
                mul_a = MUL_A_W'(state_reg);
                mul_b = MUL_B_W'(LCG_MULT);
            end
            MS_SQR:
            begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(m_reg);
            end
            MS_LN:
            begin
                mul_a = MUL_A_W'(l_reg);
                mul_b = MUL_B_W'(TWO_LN2);
            end
            MS_TH:
            begin
                mul_a = MUL_A_W'(state_reg[28:0]);
                mul_b = MUL_B_W'(HALF_PI);
            end
            MS_X2:
            begin
                mul_a = MUL_A_W'(th_reg);
                mul_b = MUL_B_W'(th_reg);
            end
            MS_TS:
            begin
                mul_a = MUL_A_W'(ts_reg);
                mul_b = x2_reg;
            end
            MS_TC:
            begin
                mul_a = MUL_A_W'(tc_reg);
                mul_b = x2_reg;
            end
            MS_OC:
            begin
                mul_a = MUL_A_W'(sq_res_reg[31:0]);
                mul_b = MUL_B_W'(co_mag_reg);
            end
            MS_OS:
            begin
                mul_a = MUL_A_W'(sq_res_reg[31:0]);
                mul_b = MUL_B_W'(si_mag_reg);
            end
            MS_RCP:
            begin
                mul_a = div_rcp_reg;
                mul_b = div_q_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pp = (cmd.mul_ph == MP_HI ? mul_a[MUL_A_W-1:MUL_AH] : mul_a[MUL_AH-1:0])
                * mul_b;

    assign lcg_sum = {1'b0, prod_reg[30:0]} + 32'(prod_reg[45:31]);
    assign lcg_red = (lcg_sum >= {1'b0, MODULUS}) ? 31'(lcg_sum - {1'b0, MODULUS})
                                                  : lcg_sum[30:0];
    assign m2 = prod_reg[61:30];
    assign sq_t = sq_res_reg + sq_bit_reg;
    assign q_est = prod_reg[PROD_W-1:RCP_W];
    assign q_mul = (DIV_W+DIVISOR_W)'(q_est) * (DIV_W+DIVISOR_W)'(div_d_reg);
    assign q_rem = div_q_reg - q_mul[DIV_W-1:0];
    assign div_ext = SUM_W'(div_q_reg);
    assign c_cl = clamp_unit(cs_reg);
    assign s_cl = clamp_unit(ss_reg);

    assign o_neg = cmd.slot[0] ? si_neg_reg : co_neg_reg;
    assign rnd = prod_reg + (PROD_W'(1) << (SH - 1));
    assign vq = rnd >> SH;
    assign lim = o_neg ? (PROD_W'(1) << (OUT_WIDTH - 1))
                       : ((PROD_W'(1) << (OUT_WIDTH - 1)) - PROD_W'(1));
    always_comb
    begin
        logic [OUT_WIDTH-1:0] mag;
        mag = (vq > lim) ? lim[OUT_WIDTH-1:0] : vq[OUT_WIDTH-1:0];
        res_val = o_neg ? (~mag + OUT_WIDTH'(1)) : mag;
    end

    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg;
        e_next = e_reg;
        frac_next = frac_reg;
        l_next = l_reg;
        sq_v_next = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        th_next = th_reg;
        x2_next = x2_reg;
        ts_next = ts_reg;
        tc_next = tc_reg;
        ss_next = ss_reg;
        cs_next = cs_reg;
        div_q_next = div_q_reg;
        div_d_next = div_d_reg;
        div_rcp_next = div_rcp_reg;
        co_neg_next = co_neg_reg;
        si_neg_next = si_neg_reg;
        co_mag_next = co_mag_reg;
        si_mag_next = si_mag_reg;

        case (cmd.mul_ph)
            MP_LO:   prod_next = PROD_W'(pp);
            MP_HI:   prod_next = prod_reg + (PROD_W'(pp) << MUL_AH);
            default: prod_next = prod_reg;
        endcase

        unique case (cmd.op)
            OP_LCG_RED:
                state_next = lcg_red;
            OP_LOG_INIT:
            begin
                m_next = state_reg;
                e_next = 5'd30;
                frac_next = '0;
            end
            OP_LOG_NORM:
            begin
                if (!m_reg[30])
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            OP_LOG_SQ:
            begin
                frac_next = {frac_reg[30:0], m2[31]};
                m_next = m2[31] ? m2[31:1] : m2[30:0];
            end
            OP_LOG_L:
                l_next = {5'd31 - e_reg, 32'd0} - {5'd0, frac_reg};
            OP_SQRT_INIT:
            begin
                sq_v_next = {prod_reg[69:32], 26'd0};
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP:
            begin
                if (sq_v_reg >= sq_t)
                begin
                    sq_v_next = sq_v_reg - sq_t;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            OP_TH_SET:
            begin
                th_next = prod_reg[61:29];
                ts_next = DIV_W'(prod_reg[61:29]);
                tc_next = DIV_W'(34'h1_0000_0000);
                ss_next = SUM_W'(prod_reg[61:29]);
                cs_next = SUM_W'(36'sh1_0000_0000);
            end
            OP_X2_SET:
                x2_next = prod_reg[65:32];
            OP_DIV_INIT:
            begin
                div_q_next = prod_reg[65:32];
                div_d_next = series_divisor(cmd.term, cmd.cos_sel);
                div_rcp_next = series_recip(cmd.term, cmd.cos_sel);
            end
            OP_DIV_STEP:
            begin
                if (q_rem >= DIV_W'(div_d_reg))
                    div_q_next = q_est + DIV_W'(1);
                else
                    div_q_next = q_est;
            end
            OP_TS_SET:
            begin
                ts_next = div_q_reg;
                ss_next = cmd.term[0] ? ss_reg + div_ext : ss_reg - div_ext;
            end
            OP_TC_SET:
            begin
                tc_next = div_q_reg;
                cs_next = cmd.term[0] ? cs_reg + div_ext : cs_reg - div_ext;
            end
            OP_TRIG:
            begin
                unique case (state_reg[30:29])
                    2'd0:
                    begin
                        co_neg_next = 1'b0; co_mag_next = c_cl;
                        si_neg_next = 1'b0; si_mag_next = s_cl;
                    end
                    2'd1:
                    begin
                        co_neg_next = 1'b1; co_mag_next = s_cl;
                        si_neg_next = 1'b0; si_mag_next = c_cl;
                    end
                    2'd2:
                    begin
                        co_neg_next = 1'b1; co_mag_next = c_cl;
                        si_neg_next = 1'b1; si_mag_next = s_cl;
                    end
                    2'd3:
                    begin
                        co_neg_next = 1'b0; co_mag_next = s_cl;
                        si_neg_next = 1'b1; si_mag_next = c_cl;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (seed_we && seed_data != '0 && seed_data != MODULUS)
            state_next = seed_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEED_W'(1);
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        m_reg <= m_next;
        e_reg <= e_next;
        frac_reg <= frac_next;
        l_reg <= l_next;
        sq_v_reg <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        th_reg <= th_next;
        x2_reg <= x2_next;
        ts_reg <= ts_next;
        tc_reg <= tc_next;
        ss_reg <= ss_next;
        cs_reg <= cs_next;
        div_q_reg <= div_q_next;
        div_d_reg <= div_d_next;
        div_rcp_reg <= div_rcp_next;
        co_neg_reg <= co_neg_next;
        si_neg_reg <= si_neg_next;
        co_mag_reg <= co_mag_next;
        si_mag_reg <= si_mag_next;
        if (cmd.op == OP_OUT_SET)
            res_reg[cmd.slot] <= res_val;
        if (cmd.out_load)
        begin
            out_w_reg <= res_reg[0];
            out_x_reg <= res_reg[1];
            out_y_reg <= res_reg[2];
            out_z_reg <= res_reg[3];
        end
    end

    assign status.norm_done = m_reg[30];
    assign comp_w = out_w_reg;
    assign comp_x = out_x_reg;
    assign comp_y = out_y_reg;
    assign comp_z = out_z_reg;

endmodule

// ----- src/gqg_ctrl.sv -----
// Controller of the Gaussian quaternion generator: sequences generator
// steps, log, square root, series and output stage, and runs the handshakes.
// Depends on gqg_pkg.
module gqg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_request,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gqg_pkg::gqg_cmd_t     cmd,
    input  gqg_pkg::gqg_status_t  status
);
    import gqg_pkg::*;

    fsm_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TERM_W-1:0]  term_reg, term_next;
    logic               pair_reg, pair_next;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            term_reg <= '0;
            pair_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            term_reg <= term_next;
            pair_reg <= pair_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        term_next = term_reg;
        pair_next = pair_reg;
        in_ready = 1'b0;
        cmd.op = OP_NONE;
        cmd.mul_sel = MS_LCG;
        cmd.mul_ph = MP_NONE;
        cmd.cos_sel = 1'b0;
        cmd.term = term_reg;
        cmd.slot = {pair_reg, 1'b0};
        cmd.out_load = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_request)
                begin
                    pair_next = 1'b0;
                    state_next = S_RL_LO;
                end
            end
            S_RL_LO:
            begin
                cmd.mul_ph = MP_LO;
                state_next = S_RL_HI;
            end
            S_RL_HI:
            begin
                cmd.mul_ph = MP_HI;
                state_next = S_RL_RED;
            end
            S_RL_RED:
            begin
                cmd.op = OP_LCG_RED;
                state_next = S_LOG_INIT;
            end
            S_LOG_INIT:
            begin
                cmd.op = OP_LOG_INIT;
                state_next = S_LOG_NORM;
            end
            S_LOG_NORM:
            begin
                cmd.op = OP_LOG_NORM;
                if (status.norm_done)
                begin
                    cnt_next = '0;
                    state_next = S_SQ_LO;
                end
            end
            S_SQ_LO:
            begin
                cmd.mul_sel = MS_SQR;
                cmd.mul_ph = MP_LO;
                state_next = S_SQ_HI;
            end
            S_SQ_HI:
            begin
                cmd.mul_sel = MS_SQR;
                cmd.mul_ph = MP_HI;
                state_next = S_SQ_UPD;
            end
            S_SQ_UPD:
            begin
                cmd.op = OP_LOG_SQ;
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = (cnt_reg == CNT_W'(LOG_ITERS - 1)) ? S_LOG_L : S_SQ_LO;
            end
            S_LOG_L:
            begin
                cmd.op = OP_LOG_L;
                state_next = S_LN_LO;
            end
            S_LN_LO:
            begin
                cmd.mul_sel = MS_LN;
                cmd.mul_ph = MP_LO;
                state_next = S_LN_HI;
            end
            S_LN_HI:
            begin
                cmd.mul_sel = MS_LN;
                cmd.mul_ph = MP_HI;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.op = OP_SQRT_INIT;
                cnt_next = '0;
                state_next = S_SQRT_STEP;
            end
            S_SQRT_STEP:
            begin
                cmd.op = OP_SQRT_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_ITERS - 1))
                    state_next = S_AL_LO;
            end
            S_AL_LO:
            begin
                cmd.mul_ph = MP_LO;
                state_next = S_AL_HI;
            end
            S_AL_HI:
            begin
                cmd.mul_ph = MP_HI;
                state_next = S_AL_RED;
            end
            S_AL_RED:
            begin
                cmd.op = OP_LCG_RED;
                state_next = S_TH_LO;
            end
            S_TH_LO:
            begin
                cmd.mul_sel = MS_TH;
                cmd.mul_ph = MP_LO;
                state_next = S_TH_HI;
            end
            S_TH_HI:
            begin
                cmd.mul_sel = MS_TH;
                cmd.mul_ph = MP_HI;
                state_next = S_TH_SET;
            end
            S_TH_SET:
            begin
                cmd.op = OP_TH_SET;
                state_next = S_X2_LO;
            end
            S_X2_LO:
            begin
                cmd.mul_sel = MS_X2;
                cmd.mul_ph = MP_LO;
                state_next = S_X2_HI;
            end
            S_X2_HI:
            begin
                cmd.mul_sel = MS_X2;
                cmd.mul_ph = MP_HI;
                state_next = S_X2_SET;
            end
            S_X2_SET:
            begin
                cmd.op = OP_X2_SET;
                term_next = '0;
                state_next = S_TS_LO;
            end
            S_TS_LO:
            begin
                cmd.mul_sel = MS_TS;
                cmd.mul_ph = MP_LO;
                state_next = S_TS_HI;
            end
            S_TS_HI:
            begin
                cmd.mul_sel = MS_TS;
                cmd.mul_ph = MP_HI;
                state_next = S_TS_DIVI;
            end
            S_TS_DIVI:
            begin
                cmd.op = OP_DIV_INIT;
                cnt_next = '0;
                state_next = S_TS_DIV;
            end
            S_TS_DIV:
            begin
                cmd.mul_sel = MS_RCP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '0)
                    cmd.mul_ph = MP_LO;
                else if (cnt_reg == CNT_W'(1))
                    cmd.mul_ph = MP_HI;
                else
                begin
                    cmd.op = OP_DIV_STEP;
                    state_next = S_TS_SET;
                end
            end
            S_TS_SET:
            begin
                cmd.op = OP_TS_SET;
                state_next = S_TC_LO;
            end
            S_TC_LO:
            begin
                cmd.mul_sel = MS_TC;
                cmd.mul_ph = MP_LO;
                state_next = S_TC_HI;
            end
            S_TC_HI:
            begin
                cmd.mul_sel = MS_TC;
                cmd.mul_ph = MP_HI;
                state_next = S_TC_DIVI;
            end
            S_TC_DIVI:
            begin
                cmd.op = OP_DIV_INIT;
                cmd.cos_sel = 1'b1;
                cnt_next = '0;
                state_next = S_TC_DIV;
            end
            S_TC_DIV:
            begin
                cmd.mul_sel = MS_RCP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '0)
                    cmd.mul_ph = MP_LO;
                else if (cnt_reg == CNT_W'(1))
                    cmd.mul_ph = MP_HI;
                else
                begin
                    cmd.op = OP_DIV_STEP;
                    state_next = S_TC_SET;
                end
            end
            S_TC_SET:
            begin
                cmd.op = OP_TC_SET;
                term_next = term_reg + TERM_W'(1);
                state_next = (term_reg == TERM_W'(SERIES_TERMS - 1)) ? S_TRIG : S_TS_LO;
            end
            S_TRIG:
            begin
                cmd.op = OP_TRIG;
                state_next = S_OC_LO;
            end
            S_OC_LO:
            begin
                cmd.mul_sel = MS_OC;
                cmd.mul_ph = MP_LO;
                state_next = S_OC_HI;
            end
            S_OC_HI:
            begin
                cmd.mul_sel = MS_OC;
                cmd.mul_ph = MP_HI;
                state_next = S_OC_SET;
            end
            S_OC_SET:
            begin
                cmd.op = OP_OUT_SET;
                state_next = S_OS_LO;
            end
            S_OS_LO:
            begin
                cmd.mul_sel = MS_OS;
                cmd.mul_ph = MP_LO;
                state_next = S_OS_HI;
            end
            S_OS_HI:
            begin
                cmd.mul_sel = MS_OS;
                cmd.mul_ph = MP_HI;
                state_next = S_OS_SET;
            end
            S_OS_SET:
            begin
                cmd.op = OP_OUT_SET;
                cmd.slot = {pair_reg, 1'b1};
                pair_next = 1'b1;
                state_next = pair_reg ? S_DONE : S_RL_LO;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/gaussian_quaternion_generator_top.sv -----
// Top level of the Gaussian quaternion generator: controller and datapath
// joined by command and status, channel interfaces on the ports.
// Depends on gqg_pkg, gqg_if, gqg_ctrl and gqg_datapath.

// Each request word with request set steps the minimal standard generator
// four times and returns one word of four normal samples in signed fixed
// point (FRAC_BITS fraction bits, OUT_WIDTH total, saturated). The time
// from acceptance to result is set by the shared split multiplier: per
// sample pair the 32-step squaring loop of the logarithm, the 32-step
// square root and the eight-term sin/cos series with division by
// reciprocal multiplication; it varies with the normalizing shift of the
// generator value. A request word with request clear is taken and
// produces nothing. The block takes the next request while a result still
// waits on the output. A seed write of zero or of all ones is dropped.
module gaussian_quaternion_generator_top #(
    parameter int OUT_WIDTH = gqg_pkg::OUT_WIDTH_DEF,
    parameter int FRAC_BITS = gqg_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    gqg_req_if.sink           req,
    gqg_cfg_if.sink           cfg,
    gqg_quat_if.source        quat
);
    import gqg_pkg::*;

    gqg_cmd_t     cmd;
    gqg_status_t  status;
    logic         in_ready;
    logic         out_valid;

    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;
    assign quat.valid = out_valid;

    gqg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_request (req.request),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (quat.ready),
        .cmd        (cmd),
        .status     (status)
    );

    gqg_datapath #(
        .OUT_WIDTH (OUT_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .seed_we   (cfg.valid && cfg.ready),
        .seed_data (cfg.seed_value),
        .comp_w    (quat.comp_w),
        .comp_x    (quat.comp_x),
        .comp_y    (quat.comp_y),
        .comp_z    (quat.comp_z)
    );

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && in_ready && req.request |=> !in_ready)
        else $error("block still ready after a request was taken");

    a_empty_request_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && in_ready && !req.request |=> in_ready)
        else $error("empty request started work");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result shown without an output load");

endmodule
